// ===== rtl/dasd_pkg.sv =====
// ----------------------------------------------------------------------------
// Date add/subtract days: shared package
// Control word and status types, sequencer program and calendar helpers.
// ----------------------------------------------------------------------------
package dasd_pkg;

    // Field widths of the transactions.
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int MOD_W       = 9;
    localparam int M_TDATA_W   = 24;
    localparam int S_FIXED_W   = YEAR_W + MONTH_W + DAY_W;

    // Calendar constants.
    localparam logic [YEAR_W-1:0]  YEAR_MIN    = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE  = YEAR_W'(400);
    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_MOD,
        OP_CLAMP,
        OP_FWD,
        OP_BWD,
        OP_FINISH
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_GE400,
        COND_BACK,
        COND_STOP,
        COND_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // Program step addresses.
    localparam step_t STEP_MOD      = STEP_W'(0);
    localparam step_t STEP_CLAMP    = STEP_W'(1);
    localparam step_t STEP_DISPATCH = STEP_W'(2);
    localparam step_t STEP_FWD      = STEP_W'(3);
    localparam step_t STEP_FWD_EXIT = STEP_W'(4);
    localparam step_t STEP_BWD      = STEP_W'(5);
    localparam step_t STEP_FINISH   = STEP_W'(6);

    // One control word: operation, jump condition, polarity and target.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  invert;
        step_t target;
    } ctrl_t;

    // Status flags returned by the datapath to the sequencer.
    typedef struct packed {
        logic ge400;
        logic back;
        logic stop;
    } status_t;

    // Program table. A step jumps to its target when the condition (xor the
    // invert bit) holds, and otherwise falls through to the next step.
    function automatic ctrl_t seq_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_MOD:      w = '{OP_MOD,    COND_GE400,    1'b0, STEP_MOD};
            STEP_CLAMP:    w = '{OP_CLAMP,  COND_ALWAYS,   1'b1, STEP_MOD};
            STEP_DISPATCH: w = '{OP_NOP,    COND_BACK,     1'b0, STEP_BWD};
            STEP_FWD:      w = '{OP_FWD,    COND_STOP,     1'b1, STEP_FWD};
            STEP_FWD_EXIT: w = '{OP_NOP,    COND_ALWAYS,   1'b0, STEP_FINISH};
            STEP_BWD:      w = '{OP_BWD,    COND_STOP,     1'b1, STEP_BWD};
            STEP_FINISH:   w = '{OP_FINISH, COND_OUT_BUSY, 1'b0, STEP_FINISH};
            default:       w = '{OP_NOP,    COND_ALWAYS,   1'b0, STEP_FINISH};
        endcase
        return w;
    endfunction

    // Leap rule on the year reduced modulo 400: divisible by 4, except the
    // centuries that are not a multiple of 400.
    function automatic logic leap_of(input logic [MOD_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != MOD_W'(100)) && (r != MOD_W'(200))
               && (r != MOD_W'(300));
    endfunction

    // Month length table.
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month) inside
            MONTH_W'(2):                                    len = leap ? DAY_W'(29) : DAY_W'(28);
            MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(30);
            default:                                        len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/dasd_datapath.sv =====
// ----------------------------------------------------------------------------
// Date add/subtract days: datapath
// Holds the walking date and remaining count; executes one operation a cycle.
// ----------------------------------------------------------------------------
module dasd_datapath #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          req_type,
    input  logic [dasd_pkg::YEAR_W-1:0]   start_year,
    input  logic [dasd_pkg::MONTH_W-1:0]  start_month,
    input  logic [dasd_pkg::DAY_W-1:0]    start_day,
    input  logic [COUNT_WIDTH-1:0]        day_count,
    input  dasd_pkg::op_t                 op,
    output dasd_pkg::status_t             status,
    output logic [dasd_pkg::YEAR_W-1:0]   result_year,
    output logic [dasd_pkg::MONTH_W-1:0]  result_month,
    output logic [dasd_pkg::DAY_W-1:0]    result_day,
    output logic                          range_error
);

    localparam int YW = dasd_pkg::YEAR_W;
    localparam int MW = dasd_pkg::MONTH_W;
    localparam int DW = dasd_pkg::DAY_W;
    localparam int RW = dasd_pkg::MOD_W;

    logic                   back_reg;
    logic [YW-1:0]          year_reg;
    logic [YW-1:0]          m400_reg;
    logic [MW-1:0]          month_reg;
    logic [DW-1:0]          day_reg;
    logic [COUNT_WIDTH-1:0] n_reg;
    logic                   err_reg;

    logic [MW-1:0]          month_in;
    logic [RW-1:0]          r_cur;
    logic [DW-1:0]          len_cur;
    logic [DW-1:0]          room;
    logic [COUNT_WIDTH-1:0] room_ext;
    logic [COUNT_WIDTH-1:0] day_ext;
    logic                   fwd_cross;
    logic                   bwd_cross;
    logic                   year_dec;
    logic [MW-1:0]          month_dec;
    logic [RW-1:0]          r_dec;
    logic [DW-1:0]          len_prev;
    logic                   stop;

    // Clamp the start month into 1..12 on load.
    always_comb begin
        if (start_month < dasd_pkg::MONTH_FIRST) begin
            month_in = dasd_pkg::MONTH_FIRST;
        end else if (start_month > dasd_pkg::MONTH_LAST) begin
            month_in = dasd_pkg::MONTH_LAST;
        end else begin
            month_in = start_month;
        end
    end

    // Length of the current month and the forward crossing test.
    assign r_cur     = m400_reg[RW-1:0];
    assign len_cur   = dasd_pkg::month_len(dasd_pkg::leap_of(r_cur), month_reg);
    assign room      = len_cur - day_reg;
    assign room_ext  = {{(COUNT_WIDTH-DW){1'b0}}, room};
    assign day_ext   = {{(COUNT_WIDTH-DW){1'b0}}, day_reg};
    assign fwd_cross = n_reg > room_ext;
    assign bwd_cross = n_reg >= day_ext;

    // Previous month, with the year stepping back when leaving January.
    assign year_dec  = month_reg == dasd_pkg::MONTH_FIRST;
    assign month_dec = year_dec ? dasd_pkg::MONTH_LAST : month_reg - MW'(1);
    assign r_dec     = (r_cur == '0) ? RW'(399) : r_cur - RW'(1);
    assign len_prev  = dasd_pkg::month_len(dasd_pkg::leap_of(year_dec ? r_dec : r_cur),
                                           month_dec);

    // Status for the sequencer.
    assign stop         = (n_reg == '0) || err_reg;
    assign status.ge400 = m400_reg >= dasd_pkg::LEAP_CYCLE;
    assign status.back  = back_reg;
    assign status.stop  = stop;

    // Working registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            back_reg  <= req_type;
            year_reg  <= start_year;
            m400_reg  <= start_year;
            month_reg <= month_in;
            day_reg   <= start_day;
            n_reg     <= day_count;
            err_reg   <= 1'b0;
        end else begin
            case (op)
                dasd_pkg::OP_MOD: begin
                    if (status.ge400) begin
                        m400_reg <= m400_reg - dasd_pkg::LEAP_CYCLE;
                    end
                end
                dasd_pkg::OP_CLAMP: begin
                    if (day_reg == '0) begin
                        day_reg <= DW'(1);
                    end else if (day_reg > len_cur) begin
                        day_reg <= len_cur;
                    end
                end
                dasd_pkg::OP_FWD: begin
                    if (!stop) begin
                        if (fwd_cross) begin
                            n_reg   <= n_reg - room_ext;
                            day_reg <= '0;
                            if (month_reg == dasd_pkg::MONTH_LAST) begin
                                month_reg <= dasd_pkg::MONTH_FIRST;
                                if (year_reg >= dasd_pkg::YEAR_MAX) begin
                                    err_reg <= 1'b1;
                                end else begin
                                    year_reg <= year_reg + YW'(1);
                                    m400_reg <= (r_cur == RW'(399)) ? '0
                                                : m400_reg + YW'(1);
                                end
                            end else begin
                                month_reg <= month_reg + MW'(1);
                            end
                        end else begin
                            day_reg <= day_reg + n_reg[DW-1:0];
                            n_reg   <= '0;
                        end
                    end
                end
                dasd_pkg::OP_BWD: begin
                    if (!stop) begin
                        if (bwd_cross) begin
                            n_reg     <= n_reg - day_ext;
                            month_reg <= month_dec;
                            day_reg   <= len_prev;
                            if (year_dec) begin
                                if (year_reg <= dasd_pkg::YEAR_MIN) begin
                                    err_reg <= 1'b1;
                                end else begin
                                    year_reg <= year_reg - YW'(1);
                                    m400_reg <= {{(YW-RW){1'b0}}, r_dec};
                                end
                            end
                        end else begin
                            day_reg <= day_reg - n_reg[DW-1:0];
                            n_reg   <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Final date and range check.
    assign result_year  = year_reg;
    assign result_month = month_reg;
    assign result_day   = day_reg;
    assign range_error  = err_reg || (year_reg < dasd_pkg::YEAR_MIN)
                          || (year_reg > dasd_pkg::YEAR_MAX);

endmodule

// ===== rtl/date_add_subtract_days_core.sv =====
// From the input transaction to a valid result: the modulo step reduces the year modulo 400
// (the start year divided by 400 is up to 40), then clamp and dispatch run, then a forward
// or backward step per month crossed plus one for a part-month remainder, a forward exit
// step on the forward path, and the finishing step, which waits while the output is stalled.
// A 16-bit count crosses up to about 2150 months. One transaction at a time: the next is
// accepted once the result is registered. Reset clears the sequencer and output valid flag.
// ----------------------------------------------------------------------------
// Date add/subtract days: top level
// Microcoded sequencer that moves a Gregorian date forward or back by a count
// of days, walking one month per step over the datapath.
// ----------------------------------------------------------------------------
module date_add_subtract_days_core #(
    parameter int  COUNT_WIDTH = 16,
    localparam int S_TDATA_W   = ((dasd_pkg::S_FIXED_W + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], day_count, zero pad
    input  logic [S_TDATA_W-1:0]           s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero pad
    output logic [dasd_pkg::M_TDATA_W-1:0] m_tdata,
    // range_error
    output logic                           m_tuser
);

    localparam int YW = dasd_pkg::YEAR_W;
    localparam int MW = dasd_pkg::MONTH_W;
    localparam int DW = dasd_pkg::DAY_W;

    logic                           busy_reg;
    dasd_pkg::step_t                step_reg;
    dasd_pkg::step_t                step_next;
    logic                           m_tvalid_reg;
    logic [dasd_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;

    dasd_pkg::ctrl_t   ctrl;
    dasd_pkg::status_t status;
    dasd_pkg::op_t     exec_op;
    logic              accept;
    logic              out_free;
    logic              cond_raw;
    logic              finish_fire;
    logic [YW-1:0]     res_year;
    logic [MW-1:0]     res_month;
    logic [DW-1:0]     res_day;
    logic              res_err;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Current control word from the program table.
    assign ctrl    = dasd_pkg::seq_rom(step_reg);
    assign exec_op = busy_reg ? ctrl.op : dasd_pkg::OP_NOP;

    // Datapath holding the date being walked.
    dasd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .load         (accept),
        .req_type     (s_tuser),
        .start_year   (s_tdata[YW-1:0]),
        .start_month  (s_tdata[YW +: MW]),
        .start_day    (s_tdata[YW+MW +: DW]),
        .day_count    (s_tdata[dasd_pkg::S_FIXED_W +: COUNT_WIDTH]),
        .op           (exec_op),
        .status       (status),
        .result_year  (res_year),
        .result_month (res_month),
        .result_day   (res_day),
        .range_error  (res_err)
    );

    // Jump condition and next step.
    always_comb begin
        unique case (ctrl.cond)
            dasd_pkg::COND_ALWAYS:   cond_raw = 1'b1;
            dasd_pkg::COND_GE400:    cond_raw = status.ge400;
            dasd_pkg::COND_BACK:     cond_raw = status.back;
            dasd_pkg::COND_STOP:     cond_raw = status.stop;
            dasd_pkg::COND_OUT_BUSY: cond_raw = !out_free;
            default:                 cond_raw = 1'b0;
        endcase
        if (cond_raw ^ ctrl.invert) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + dasd_pkg::STEP_W'(1);
        end
    end

    assign finish_fire = busy_reg && (ctrl.op == dasd_pkg::OP_FINISH) && out_free;

    // Sequencer and output handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= dasd_pkg::STEP_MOD;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                step_reg <= dasd_pkg::STEP_MOD;
            end else if (finish_fire) begin
                busy_reg <= 1'b0;
                step_reg <= dasd_pkg::STEP_MOD;
            end else if (busy_reg) begin
                step_reg <= step_next;
            end
            // The finishing step fills the output; a taken result empties it.
            if (finish_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result register; a range error forces the date fields to zero.
    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            m_tuser_reg <= res_err;
            if (res_err) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {{(dasd_pkg::M_TDATA_W-dasd_pkg::S_FIXED_W){1'b0}},
                                res_day, res_month, res_year};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An accepted transaction starts the program from its first step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && (step_reg == dasd_pkg::STEP_MOD))
        else $error("sequencer did not start after an input transaction");

    // The step counter rests at the first step whenever the block is idle.
    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (step_reg == dasd_pkg::STEP_MOD))
        else $error("step counter moved while idle");

    // A result only appears after the finishing step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg)
                                && ($past(step_reg) == dasd_pkg::STEP_FINISH))
        else $error("result raised outside the finishing step");

    // A range error carries an all-zero date.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("range error with a non-zero date");

endmodule
